// File: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL; empty bodies when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// ante holds in a cycle -> cons holds in the same cycle
`define SVET_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");
// ante holds in a cycle -> cons holds in the next cycle
`define SVET_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define SVET_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define SVET_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

// File: rtl/core/svet_pkg.sv
// Shared types and constants for the segment versus edge table block.
package svet_pkg;

   localparam int MAX_EDGES_DEF   = 64;
   localparam int COORD_WIDTH_DEF = 16;
   localparam int SLOT_W          = 6;
   localparam int CSR_W           = 7;

   localparam logic OP_STORE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // tag that travels with each table entry through the test pipeline
   typedef struct packed {
      logic vld;    // entry index is below edges_in_use
      logic last;   // final entry of the sweep
   } tag_type;

endpackage

// File: rtl/core/svet_cell.sv
// One edge register of the rotating table ring.
module svet_cell #(
   parameter int COORD_WIDTH = svet_pkg::COORD_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       load_en,
   input  logic [4*COORD_WIDTH-1:0]   load_data,
   input  logic                       shift_en,
   input  logic [4*COORD_WIDTH-1:0]   shift_data,
   output logic [4*COORD_WIDTH-1:0]   cell_data
);

   logic [4*COORD_WIDTH-1:0] edge_ff;

   always_ff @(posedge clock) begin
      if (load_en) begin
         edge_ff <= load_data;
      end else if (shift_en) begin
         edge_ff <= shift_data;
      end
   end

   assign cell_data = edge_ff;

endmodule

// File: rtl/core/svet_cross.sv
// Three-stage crossing test of one table edge against the query edge.
module svet_cross #(
   parameter int COORD_WIDTH = svet_pkg::COORD_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  svet_pkg::tag_type          in_tag,
   input  logic [4*COORD_WIDTH-1:0]   edge_data,
   input  logic [4*COORD_WIDTH-1:0]   qry_data,
   output svet_pkg::tag_type          out_tag,
   output logic                       out_hit
);

   localparam int W  = COORD_WIDTH;
   localparam int DW = W + 1;
   localparam int PW = 2 * DW;
   localparam int SW = PW + 1;

   logic signed [W-1:0] e_x1, e_y1, e_x2, e_y2;
   logic signed [W-1:0] q_x1, q_y1, q_x2, q_y2;

   assign e_x1 = edge_data[4*W-1 -: W];
   assign e_y1 = edge_data[3*W-1 -: W];
   assign e_x2 = edge_data[2*W-1 -: W];
   assign e_y2 = edge_data[W-1 -: W];
   assign q_x1 = qry_data[4*W-1 -: W];
   assign q_y1 = qry_data[3*W-1 -: W];
   assign q_x2 = qry_data[2*W-1 -: W];
   assign q_y2 = qry_data[W-1 -: W];

   // sides 0,1: query endpoints against the edge line
   // sides 2,3: edge endpoints against the query line
   logic signed [DW-1:0] a_in [4];
   logic signed [DW-1:0] d_in [4];
   logic signed [DW-1:0] be_in, ce_in, bq_in, cq_in;
   logic                 skip_in;

   always_comb begin
      be_in = DW'(e_x1) - DW'(e_x2);
      ce_in = DW'(e_y1) - DW'(e_y2);
      bq_in = DW'(q_x1) - DW'(q_x2);
      cq_in = DW'(q_y1) - DW'(q_y2);
      a_in[0] = DW'(q_y1) - DW'(e_y1);
      d_in[0] = DW'(q_x1) - DW'(e_x1);
      a_in[1] = DW'(q_y2) - DW'(e_y1);
      d_in[1] = DW'(q_x2) - DW'(e_x1);
      a_in[2] = DW'(e_y1) - DW'(q_y1);
      d_in[2] = DW'(e_x1) - DW'(q_x1);
      a_in[3] = DW'(e_y2) - DW'(q_y1);
      d_in[3] = DW'(e_x2) - DW'(q_x1);
      skip_in = ((e_x1 == q_x1) && (e_y1 == q_y1)) ||
                ((e_x1 == q_x2) && (e_y1 == q_y2)) ||
                ((e_x2 == q_x1) && (e_y2 == q_y1)) ||
                ((e_x2 == q_x2) && (e_y2 == q_y2));
   end

   // stage 1: differences
   logic signed [DW-1:0] a_ff [4];
   logic signed [DW-1:0] d_ff [4];
   logic signed [DW-1:0] be_ff, ce_ff, bq_ff, cq_ff;
   logic                 skip1_ff;
   svet_pkg::tag_type    tag1_ff;

   // stage 2: products
   logic signed [PW-1:0] ab_ff [4];
   logic signed [PW-1:0] cd_ff [4];
   logic [3:0]           bzero_ff, bneg_ff, dneg_ff;
   logic                 skip2_ff;
   svet_pkg::tag_type    tag2_ff;

   // stage 3: side decision
   logic                 hit_ff;
   svet_pkg::tag_type    tag3_ff;

   logic signed [DW-1:0] b_sel [4];
   logic signed [DW-1:0] c_sel [4];
   logic signed [SW-1:0] diff  [4];
   logic [3:0]           side;
   logic                 hit_in;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         b_sel[i] = (i < 2) ? be_ff : bq_ff;
         c_sel[i] = (i < 2) ? ce_ff : cq_ff;
         diff[i]  = SW'(ab_ff[i]) - SW'(cd_ff[i]);
         if (bzero_ff[i]) begin
            side[i] = !dneg_ff[i];           // vertical line: x test
         end else if (bneg_ff[i]) begin
            side[i] = (diff[i] <= 0);
         end else begin
            side[i] = (diff[i] >= 0);
         end
      end
      hit_in = tag2_ff.vld && !skip2_ff && (side[0] != side[1]) && (side[2] != side[3]);
   end

   always_ff @(posedge clock) begin
      a_ff     <= a_in;
      d_ff     <= d_in;
      be_ff    <= be_in;
      ce_ff    <= ce_in;
      bq_ff    <= bq_in;
      cq_ff    <= cq_in;
      skip1_ff <= skip_in;
      for (int i = 0; i < 4; i++) begin
         ab_ff[i]    <= a_ff[i] * b_sel[i];
         cd_ff[i]    <= c_sel[i] * d_ff[i];
         bzero_ff[i] <= (b_sel[i] == '0);
         bneg_ff[i]  <= b_sel[i][DW-1];
         dneg_ff[i]  <= d_ff[i][DW-1];
      end
      skip2_ff <= skip1_ff;
      hit_ff   <= hit_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
         tag3_ff <= '0;
      end else begin
         tag1_ff <= in_tag;
         tag2_ff <= tag1_ff;
         tag3_ff <= tag2_ff;
      end
   end

   assign out_tag = tag3_ff;
   assign out_hit = hit_ff;

endmodule

// File: rtl/core/segment_vs_edge_table_intersect.sv
// A query returns rsp_strobe once the last ring entry has left the crossing test.
// Queries do not overlap: busy holds until the response, while one full turn of the
//   edge ring passes the shared three-stage crossing test; a store is taken only when idle.
// Reset (synchronous, active high) clears control and edges_in_use; table
//   contents are undefined until written. The receiver cannot stall rsp_strobe.
`include "assert_macros.svh"

module segment_vs_edge_table_intersect #(
   parameter int MAX_EDGES   = svet_pkg::MAX_EDGES_DEF,
   parameter int COORD_WIDTH = svet_pkg::COORD_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_op,
   input  logic [svet_pkg::SLOT_W-1:0]       req_slot,
   input  logic signed [COORD_WIDTH-1:0]     req_ax,
   input  logic signed [COORD_WIDTH-1:0]     req_ay,
   input  logic signed [COORD_WIDTH-1:0]     req_bx,
   input  logic signed [COORD_WIDTH-1:0]     req_by,
   output logic                              rsp_strobe,
   output logic                              rsp_hit,
   input  logic                              csr_wr_en,
   input  logic [svet_pkg::CSR_W-1:0]        csr_wr_data
);

   localparam int EW = 4 * COORD_WIDTH;
   localparam int KW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam logic [KW-1:0] K_LAST = KW'(MAX_EDGES - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN
   } state_type;

   state_type                   state_ff;
   logic [KW-1:0]               k_ff;
   logic                        acc_ff;
   logic                        rsp_strobe_ff;
   logic                        rsp_hit_ff;
   logic [EW-1:0]               qry_ff;
   logic [svet_pkg::CSR_W-1:0]  csr_edges_ff;

   logic                        store_go;
   logic [EW-1:0]               req_edge;
   logic [EW-1:0]               ring [MAX_EDGES];
   svet_pkg::tag_type           feed_tag;
   svet_pkg::tag_type           x_tag;
   logic                        x_hit;

   assign busy     = (state_ff != ST_IDLE);
   assign store_go = start && !busy && (req_op == svet_pkg::OP_STORE);
   assign req_edge = {req_ax, req_ay, req_bx, req_by};

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_edges_ff <= '0;
      end else if (csr_wr_en) begin
         csr_edges_ff <= csr_wr_data;
      end
   end

   // ring rotates toward cell 0 once per cycle during a sweep
   for (genvar i = 0; i < MAX_EDGES; i++) begin : g_cell
      svet_cell #(
         .COORD_WIDTH (COORD_WIDTH)
      ) u_cell (
         .clock      (clock),
         .load_en    (store_go && (32'(req_slot) == i)),
         .load_data  (req_edge),
         .shift_en   (state_ff == ST_RUN),
         .shift_data (ring[(i + 1) % MAX_EDGES]),
         .cell_data  (ring[i])
      );
   end

   always_comb begin
      feed_tag.vld  = (state_ff == ST_RUN) && (32'(k_ff) < 32'(csr_edges_ff));
      feed_tag.last = (state_ff == ST_RUN) && (k_ff == K_LAST);
   end

   svet_cross #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_cross (
      .clock     (clock),
      .reset     (reset),
      .in_tag    (feed_tag),
      .edge_data (ring[0]),
      .qry_data  (qry_ff),
      .out_tag   (x_tag),
      .out_hit   (x_hit)
   );

   // valid tags only leave the crossing test during RUN and DRAIN
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         k_ff          <= '0;
         acc_ff        <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               rsp_strobe_ff <= 1'b0;
               if (start && (req_op == svet_pkg::OP_QUERY)) begin
                  qry_ff   <= req_edge;
                  k_ff     <= '0;
                  acc_ff   <= 1'b0;
                  state_ff <= ST_RUN;
               end
            end
            ST_RUN: begin
               rsp_strobe_ff <= 1'b0;
               k_ff          <= k_ff + KW'(1);
               if (x_tag.vld) begin
                  acc_ff <= acc_ff | x_hit;
               end
               if (k_ff == K_LAST) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               rsp_strobe_ff <= x_tag.last;
               if (x_tag.last) begin
                  rsp_hit_ff <= acc_ff | (x_tag.vld & x_hit);
                  acc_ff     <= 1'b0;
                  state_ff   <= ST_IDLE;
               end else if (x_tag.vld) begin
                  acc_ff <= acc_ff | x_hit;
               end
            end
            default: begin
               rsp_strobe_ff <= 1'b0;
               state_ff      <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_hit    = rsp_hit_ff;

   `SVET_ASSERT_IMP(a_strobe_idle, clock, reset, rsp_strobe_ff, state_ff == ST_IDLE)
   `SVET_ASSERT_NXT(a_query_busy, clock, reset, start && !busy && (req_op == svet_pkg::OP_QUERY), busy)
   `SVET_ASSERT_NXT(a_sweep_end, clock, reset, (state_ff == ST_RUN) && (k_ff == K_LAST), state_ff == ST_DRAIN)
   `SVET_ASSERT_NXT(a_single_beat, clock, reset, rsp_strobe_ff, !rsp_strobe_ff)
   `SVET_ASSERT_IMP(a_last_in_drain, clock, reset, x_tag.last, state_ff == ST_DRAIN)

endmodule
